[hdl/swept_sphere_sphere_intersect_macros.svh]
// assertion macros for the swept sphere intersect block
`ifndef SWEPT_SPHERE_SPHERE_INTERSECT_MACROS_SVH
`define SWEPT_SPHERE_SPHERE_INTERSECT_MACROS_SVH
`ifndef SYNTHESIS
`define SSI_ASSERT(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("%m: check failed");
`define SSI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");
`else
`define SSI_ASSERT(lbl, clk, rstn, cond)
`define SSI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/ssi_pkg.sv]
// shared constants, types and width helpers of the swept sphere intersect block
`timescale 1ns / 1ps
package ssi_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF   = 16;
    localparam int unsigned LIMB_WIDTH      = 32;
    localparam int unsigned WMUL_LATENCY    = 3;
    localparam int unsigned FIFO_DEPTH      = 4;

    typedef enum logic [2:0] {
        K_ZERO,
        K_MISS,
        K_EARLY,
        K_ADD,
        K_SUB
    } t_kind;

    // width of v.v
    function automatic int unsigned f_aw(int unsigned w);
        return 2 * w;
    endfunction

    // width of |d.v|
    function automatic int unsigned f_hw(int unsigned w);
        return 2 * w + 1;
    endfunction

    // width of |d.d - (r1+r2)^2|
    function automatic int unsigned f_cw(int unsigned w);
        return 2 * w + 2;
    endfunction

endpackage

[hdl/ssi_front.sv]
// front end: differences, dot products and root classification
`timescale 1ns / 1ps
module ssi_front
    import ssi_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    input  logic        [COORD_WIDTH-2:0] i_mover_radius,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_z,
    input  logic        [COORD_WIDTH-2:0] i_target_radius,
    output logic                          o_valid,
    input  logic                          i_next_full,
    output t_kind                         o_kind,
    output logic [2*COORD_WIDTH-1:0]      o_a,
    output logic [2*COORD_WIDTH:0]        o_hm,
    output logic [2*COORD_WIDTH+1:0]      o_cm,
    output logic                          o_cneg
);

    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned AW = f_aw(W);
    localparam int unsigned HW = f_hw(W);
    localparam int unsigned CW = f_cw(W);

    logic en;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic signed [W:0]   r1_d [3];
    logic signed [W-1:0] r1_v [3];
    logic [W-1:0]        r1_rr;

    logic [AW-1:0]       r2_vv [3];
    logic signed [2*W:0] r2_dv [3];
    logic [2*W:0]        r2_dd [3];
    logic [2*W-1:0]      r2_rr2;

    logic [AW-1:0]       r3_a;
    logic signed [HW:0]  r3_h;
    logic [CW-1:0]       r3_cp;
    logic [2*W-1:0]      r3_rr2;

    t_kind               r4_kind;
    logic [AW-1:0]       r4_a;
    logic [HW-1:0]       r4_hm;
    logic [CW-1:0]       r4_cm;
    logic                r4_cneg;

    logic signed [W:0]     n1_d [3];
    logic [W-1:0]          n1_rr;
    logic signed [2*W-1:0] n2_vv [3];
    logic signed [2*W:0]   n2_dv [3];
    logic signed [2*W+1:0] n2_dd [3];
    logic [2*W-1:0]        n2_rr2;
    logic [AW-1:0]         n3_a;
    logic signed [HW:0]    n3_h;
    logic [CW-1:0]         n3_cp;
    logic [CW:0]           n4_c;
    logic                  n4_cneg, n4_czero, n4_hle0;
    logic [CW-1:0]         n4_cm;
    logic [HW-1:0]         n4_hm;
    t_kind                 n4_kind;

    assign en     = ~(r_v4 & i_next_full);
    assign o_full = ~en;

    assign n1_d[0] = (W+1)'(i_start_x) - (W+1)'(i_target_x);
    assign n1_d[1] = (W+1)'(i_start_y) - (W+1)'(i_target_y);
    assign n1_d[2] = (W+1)'(i_start_z) - (W+1)'(i_target_z);
    assign n1_rr   = W'(i_mover_radius) + W'(i_target_radius);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_vv[i] = (2*W)'(r1_v[i]) * (2*W)'(r1_v[i]);
            n2_dv[i] = (2*W+1)'(r1_d[i]) * (2*W+1)'(r1_v[i]);
            n2_dd[i] = (2*W+2)'(r1_d[i]) * (2*W+2)'(r1_d[i]);
        end
        n2_rr2 = (2*W)'(r1_rr) * (2*W)'(r1_rr);
    end

    assign n3_a  = r2_vv[0] + r2_vv[1] + r2_vv[2];
    assign n3_h  = (HW+1)'(r2_dv[0]) + (HW+1)'(r2_dv[1]) + (HW+1)'(r2_dv[2]);
    assign n3_cp = CW'(r2_dd[0]) + CW'(r2_dd[1]) + CW'(r2_dd[2]);

    // sign split and root choice
    always_comb begin
        n4_c     = {1'b0, r3_cp} - (CW+1)'(r3_rr2);
        n4_cneg  = n4_c[CW];
        n4_czero = (n4_c == '0);
        n4_cm    = n4_cneg ? CW'(-n4_c) : n4_c[CW-1:0];
        n4_hm    = r3_h[HW] ? HW'(-r3_h) : HW'(r3_h);
        n4_hle0  = r3_h[HW] | (r3_h == '0);
        if (r3_a == '0) begin
            n4_kind = K_ZERO;
        end else if (n4_hle0 && !n4_cneg) begin
            n4_kind = K_EARLY;
        end else if (n4_hle0) begin
            n4_kind = K_ADD;
        end else if (n4_cneg || n4_czero) begin
            n4_kind = K_SUB;
        end else begin
            n4_kind = K_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_d[i]  <= n1_d[i];
                r2_vv[i] <= AW'($unsigned(n2_vv[i]));
                r2_dv[i] <= n2_dv[i];
                r2_dd[i] <= n2_dd[i][2*W:0];
            end
            r1_v[0] <= i_dir_x;
            r1_v[1] <= i_dir_y;
            r1_v[2] <= i_dir_z;
            r1_rr   <= n1_rr;
            r2_rr2  <= n2_rr2;
            r3_a    <= n3_a;
            r3_h    <= n3_h;
            r3_cp   <= n3_cp;
            r3_rr2  <= r2_rr2;
            r4_kind <= n4_kind;
            r4_a    <= r3_a;
            r4_hm   <= n4_hm;
            r4_cm   <= n4_cm;
            r4_cneg <= n4_cneg;
        end
    end

    assign o_valid = r_v4;
    assign o_kind  = r4_kind;
    assign o_a     = r4_a;
    assign o_hm    = r4_hm;
    assign o_cm    = r4_cm;
    assign o_cneg  = r4_cneg;

endmodule

[hdl/ssi_fifo.sv]
// request queue between front and back end
`timescale 1ns / 1ps
`include "swept_sphere_sphere_intersect_macros.svh"
module ssi_fifo
    import ssi_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PW   = $clog2(DEPTH);
    localparam int unsigned CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CNTW-1:0]  r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `SSI_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, o_full, !i_push)
    `SSI_ASSERT_IMP(a_no_pop_when_empty, i_clk, i_rst_n, o_empty, !i_pop)

endmodule

[hdl/ssi_wmul.sv]
// pipelined wide unsigned multiplier built from limb products
`timescale 1ns / 1ps
module ssi_wmul
    import ssi_pkg::*;
#(
    parameter int unsigned A_WIDTH = 64,
    parameter int unsigned B_WIDTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [A_WIDTH-1:0]         i_a,
    input  logic [B_WIDTH-1:0]         i_b,
    output logic [A_WIDTH+B_WIDTH-1:0] o_p
);

    localparam int unsigned L  = LIMB_WIDTH;
    localparam int unsigned LA = (A_WIDTH + L - 1) / L;
    localparam int unsigned LB = (B_WIDTH + L - 1) / L;
    localparam int unsigned PW = (LA + LB) * L;

    logic [LA*L-1:0] a_pad;
    logic [LB*L-1:0] b_pad;
    logic [2*L-1:0]  r_pp [LA][LB];
    logic [PW-1:0]   r_row [LA];
    logic [PW-1:0]   r_sum;
    logic [PW-1:0]   n_row [LA];
    logic [PW-1:0]   n_sum;

    assign a_pad = (LA*L)'(i_a);
    assign b_pad = (LB*L)'(i_b);

    always_comb begin
        for (int i = 0; i < LA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < LB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (j * L));
            end
        end
        n_sum = '0;
        for (int i = 0; i < LA; i++) begin
            n_sum = n_sum + (r_row[i] << (i * L));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < LA; i++) begin
                for (int j = 0; j < LB; j++) begin
                    r_pp[i][j] <= a_pad[i*L +: L] * b_pad[j*L +: L];
                end
                r_row[i] <= n_row[i];
            end
            r_sum <= n_sum;
        end
    end

    assign o_p = r_sum[A_WIDTH+B_WIDTH-1:0];

endmodule

[hdl/ssi_back.sv]
// back end: discriminant, square root, quotient and result register
`timescale 1ns / 1ps
`include "swept_sphere_sphere_intersect_macros.svh"
module ssi_back
    import ssi_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_kind                    i_kind,
    input  logic [2*COORD_WIDTH-1:0] i_a,
    input  logic [2*COORD_WIDTH:0]   i_hm,
    input  logic [2*COORD_WIDTH+1:0] i_cm,
    input  logic                     i_cneg,
    output logic                     o_take,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic                     o_hit,
    output logic [COORD_WIDTH-2:0]   o_time_of_hit,
    output logic                     o_zero_velocity
);

    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned AW = f_aw(W);
    localparam int unsigned HW = f_hw(W);
    localparam int unsigned CW = f_cw(W);
    localparam int unsigned PW = 2 * HW;
    localparam int unsigned DW = 4 * W + 3;
    localparam int unsigned SW = 2 * W + 2;
    localparam int unsigned NW = 2 * W + 3;
    localparam int unsigned QW = NW + F;
    localparam int unsigned ML = WMUL_LATENCY;

    logic en;

    // request register
    logic          r0_v;
    t_kind         r0_kind;
    logic [AW-1:0] r0_a;
    logic [HW-1:0] r0_hm;
    logic [CW-1:0] r0_cm;
    logic          r0_cneg;

    // alongside the multipliers
    logic          r_mv    [ML];
    t_kind         r_mkind [ML];
    logic [AW-1:0] r_ma    [ML];
    logic [HW-1:0] r_mhm   [ML];
    logic          r_mcneg [ML];
    logic [PW-1:0] w_h2;
    logic [PW-1:0] w_ac;

    // discriminant
    logic          rd_v;
    t_kind         rd_kind;
    logic [AW-1:0] rd_a;
    logic [HW-1:0] rd_hm;
    logic [DW-1:0] rd_d;
    logic [DW-1:0] n_d;
    t_kind         n_dkind;
    logic          d_hitk;

    // square root, one result bit a stage
    logic          r_sv    [SW];
    t_kind         r_skind [SW];
    logic [AW-1:0] r_sa    [SW];
    logic [HW-1:0] r_shm   [SW];
    logic [DW:0]   r_srem  [SW];
    logic [SW-1:0] r_sq    [SW];
    logic [DW:0]   s_irem  [SW];
    logic [SW-1:0] s_iq    [SW];
    logic [DW:0]   n_srem  [SW];
    logic [SW-1:0] n_sq    [SW];

    // numerator
    logic          rn_v;
    t_kind         rn_kind;
    logic [AW-1:0] rn_a;
    logic [NW-1:0] rn_n;
    logic [NW-1:0] n_n;

    // divider, one quotient bit a stage
    logic          r_qv    [QW];
    t_kind         r_qkind [QW];
    logic [AW-1:0] r_qa    [QW];
    logic [NW-1:0] r_qn    [QW];
    logic [AW-1:0] r_qrem  [QW];
    logic [QW-1:0] r_qq    [QW];
    logic [AW-1:0] q_irem  [QW];
    logic [QW-1:0] q_iq    [QW];
    logic [AW-1:0] q_ia    [QW];
    logic [NW-1:0] q_in    [QW];
    logic [AW-1:0] n_qrem  [QW];
    logic [QW-1:0] n_qq    [QW];

    // result
    logic              r_ov;
    logic              r_hit;
    logic [W-2:0]      r_time;
    logic              r_zero;
    logic              f_hitk;
    logic [QW-1:0]     f_q;
    logic [W-2:0]      f_time;

    assign en     = ~r_ov | i_pop;
    assign o_take = en & i_valid;

    ssi_wmul #(
        .A_WIDTH(HW),
        .B_WIDTH(HW)
    ) u_h2 (
        .i_clk(i_clk),
        .i_en (en),
        .i_a  (r0_hm),
        .i_b  (r0_hm),
        .o_p  (w_h2)
    );

    ssi_wmul #(
        .A_WIDTH(AW),
        .B_WIDTH(CW)
    ) u_ac (
        .i_clk(i_clk),
        .i_en (en),
        .i_a  (r0_a),
        .i_b  (r0_cm),
        .o_p  (w_ac)
    );

    // d = h^2 - a*c, signs folded
    always_comb begin
        d_hitk = (r_mkind[ML-1] == K_EARLY) || (r_mkind[ML-1] == K_ADD) ||
                 (r_mkind[ML-1] == K_SUB);
        if (r_mcneg[ML-1]) begin
            n_d = DW'(w_h2) + DW'(w_ac);
        end else begin
            n_d = DW'(w_h2) - DW'(w_ac);
        end
        if (d_hitk && !r_mcneg[ML-1] && (w_h2 < w_ac)) begin
            n_dkind = K_MISS;
        end else begin
            n_dkind = r_mkind[ML-1];
        end
    end

    always_comb begin : p_sqrt
        logic [DW:0] t;
        s_irem[0] = {1'b0, rd_d};
        s_iq[0]   = '0;
        for (int k = 1; k < SW; k++) begin
            s_irem[k] = r_srem[k-1];
            s_iq[k]   = r_sq[k-1];
        end
        for (int k = 0; k < SW; k++) begin
            t = ((DW+1)'(s_iq[k]) << (SW - k)) | ((DW+1)'(1) << (2 * (SW - 1 - k)));
            if (s_irem[k] >= t) begin
                n_srem[k] = s_irem[k] - t;
                n_sq[k]   = s_iq[k] | (SW'(1) << (SW - 1 - k));
            end else begin
                n_srem[k] = s_irem[k];
                n_sq[k]   = s_iq[k];
            end
        end
    end

    always_comb begin
        unique case (r_skind[SW-1])
            K_EARLY: n_n = NW'(r_shm[SW-1]) - NW'(r_sq[SW-1]);
            K_ADD:   n_n = NW'(r_shm[SW-1]) + NW'(r_sq[SW-1]);
            K_SUB:   n_n = NW'(r_sq[SW-1]) - NW'(r_shm[SW-1]);
            default: n_n = '0;
        endcase
    end

    always_comb begin : p_div
        logic [QW-1:0] nn;
        logic [AW:0]   rs;
        q_irem[0] = '0;
        q_iq[0]   = '0;
        q_ia[0]   = rn_a;
        q_in[0]   = rn_n;
        for (int k = 1; k < QW; k++) begin
            q_irem[k] = r_qrem[k-1];
            q_iq[k]   = r_qq[k-1];
            q_ia[k]   = r_qa[k-1];
            q_in[k]   = r_qn[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            nn = {q_in[k], F'(0)};
            rs = {q_irem[k], nn[QW-1-k]};
            if (rs >= {1'b0, q_ia[k]}) begin
                n_qrem[k] = AW'(rs - {1'b0, q_ia[k]});
                n_qq[k]   = {q_iq[k][QW-2:0], 1'b1};
            end else begin
                n_qrem[k] = AW'(rs);
                n_qq[k]   = {q_iq[k][QW-2:0], 1'b0};
            end
        end
    end

    // saturate to the time field
    always_comb begin
        f_hitk = (r_qkind[QW-1] == K_EARLY) || (r_qkind[QW-1] == K_ADD) ||
                 (r_qkind[QW-1] == K_SUB);
        f_q    = r_qq[QW-1];
        if (!f_hitk) begin
            f_time = '0;
        end else if (f_q > QW'({(W-1){1'b1}})) begin
            f_time = '1;
        end else begin
            f_time = f_q[W-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            for (int k = 0; k < ML; k++) begin
                r_mv[k] <= 1'b0;
            end
            rd_v <= 1'b0;
            for (int k = 0; k < SW; k++) begin
                r_sv[k] <= 1'b0;
            end
            rn_v <= 1'b0;
            for (int k = 0; k < QW; k++) begin
                r_qv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r0_v    <= i_valid;
            r_mv[0] <= r0_v;
            for (int k = 1; k < ML; k++) begin
                r_mv[k] <= r_mv[k-1];
            end
            rd_v    <= r_mv[ML-1];
            r_sv[0] <= rd_v;
            for (int k = 1; k < SW; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            rn_v    <= r_sv[SW-1];
            r_qv[0] <= rn_v;
            for (int k = 1; k < QW; k++) begin
                r_qv[k] <= r_qv[k-1];
            end
            r_ov <= r_qv[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_kind <= i_kind;
            r0_a    <= i_a;
            r0_hm   <= i_hm;
            r0_cm   <= i_cm;
            r0_cneg <= i_cneg;

            r_mkind[0] <= r0_kind;
            r_ma[0]    <= r0_a;
            r_mhm[0]   <= r0_hm;
            r_mcneg[0] <= r0_cneg;
            for (int k = 1; k < ML; k++) begin
                r_mkind[k] <= r_mkind[k-1];
                r_ma[k]    <= r_ma[k-1];
                r_mhm[k]   <= r_mhm[k-1];
                r_mcneg[k] <= r_mcneg[k-1];
            end

            rd_kind <= n_dkind;
            rd_a    <= r_ma[ML-1];
            rd_hm   <= r_mhm[ML-1];
            rd_d    <= n_d;

            r_skind[0] <= rd_kind;
            r_sa[0]    <= rd_a;
            r_shm[0]   <= rd_hm;
            for (int k = 1; k < SW; k++) begin
                r_skind[k] <= r_skind[k-1];
                r_sa[k]    <= r_sa[k-1];
                r_shm[k]   <= r_shm[k-1];
            end
            for (int k = 0; k < SW; k++) begin
                r_srem[k] <= n_srem[k];
                r_sq[k]   <= n_sq[k];
            end

            rn_kind <= r_skind[SW-1];
            rn_a    <= r_sa[SW-1];
            rn_n    <= n_n;

            r_qkind[0] <= rn_kind;
            for (int k = 1; k < QW; k++) begin
                r_qkind[k] <= r_qkind[k-1];
            end
            for (int k = 0; k < QW; k++) begin
                r_qa[k]   <= q_ia[k];
                r_qn[k]   <= q_in[k];
                r_qrem[k] <= n_qrem[k];
                r_qq[k]   <= n_qq[k];
            end

            r_hit  <= f_hitk;
            r_time <= f_time;
            r_zero <= (r_qkind[QW-1] == K_ZERO);
        end
    end

    assign o_empty         = ~r_ov;
    assign o_hit           = r_hit;
    assign o_time_of_hit   = r_time;
    assign o_zero_velocity = r_zero;

    `SSI_ASSERT(a_hit_zero_excl, i_clk, i_rst_n, !(r_ov && r_hit && r_zero))
    `SSI_ASSERT_IMP(a_miss_time_zero, i_clk, i_rst_n, r_ov && !r_hit, r_time == '0)
    `SSI_ASSERT_IMP(a_early_root_le_h, i_clk, i_rst_n, r_sv[SW-1] && (r_skind[SW-1] == K_EARLY), r_sq[SW-1] <= SW'(r_shm[SW-1]))

endmodule

[hdl/swept_sphere_sphere_intersect.sv]
// top level: swept sphere against sphere contact time
// throughput: one request per cycle while results are popped as they arrive
// every square root and quotient bit has a pipeline stage
// a four deep queue between front and back end lets each side stall on its own
// reset: synchronous, active low; clears valid bits and queue pointers, no clearing pass
`timescale 1ns / 1ps
module swept_sphere_sphere_intersect
    import ssi_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    input  logic        [COORD_WIDTH-2:0] i_mover_radius,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_z,
    input  logic        [COORD_WIDTH-2:0] i_target_radius,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_hit,
    output logic        [COORD_WIDTH-2:0] o_time_of_hit,
    output logic                          o_zero_velocity
);

    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned AW = f_aw(W);
    localparam int unsigned HW = f_hw(W);
    localparam int unsigned CW = f_cw(W);
    localparam int unsigned KW = $bits(t_kind);
    localparam int unsigned QD = KW + AW + HW + CW + 1;

    logic          f_valid, q_full, q_empty, b_take;
    t_kind         f_kind, b_kind;
    logic [AW-1:0] f_a, b_a;
    logic [HW-1:0] f_hm, b_hm;
    logic [CW-1:0] f_cm, b_cm;
    logic          f_cneg, b_cneg;
    logic [QD-1:0] q_wdata, q_rdata;

    ssi_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_start_z      (i_start_z),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .i_mover_radius (i_mover_radius),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_target_z     (i_target_z),
        .i_target_radius(i_target_radius),
        .o_valid        (f_valid),
        .i_next_full    (q_full),
        .o_kind         (f_kind),
        .o_a            (f_a),
        .o_hm           (f_hm),
        .o_cm           (f_cm),
        .o_cneg         (f_cneg)
    );

    assign q_wdata = {f_kind, f_a, f_hm, f_cm, f_cneg};

    ssi_fifo #(
        .WIDTH(QD),
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_valid & ~q_full),
        .i_data (q_wdata),
        .o_full (q_full),
        .i_pop  (b_take),
        .o_data (q_rdata),
        .o_empty(q_empty)
    );

    assign b_kind = t_kind'(q_rdata[QD-1 -: KW]);
    assign b_a    = q_rdata[HW+CW+1 +: AW];
    assign b_hm   = q_rdata[CW+1 +: HW];
    assign b_cm   = q_rdata[1 +: CW];
    assign b_cneg = q_rdata[0];

    ssi_back #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (~q_empty),
        .i_kind         (b_kind),
        .i_a            (b_a),
        .i_hm           (b_hm),
        .i_cm           (b_cm),
        .i_cneg         (b_cneg),
        .o_take         (b_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_hit          (o_hit),
        .o_time_of_hit  (o_time_of_hit),
        .o_zero_velocity(o_zero_velocity)
    );

endmodule

[verif/tb.sv]
// testbench for the swept sphere contact block: predicted results checked in order
`timescale 1ns / 1ps
module tb;
    import ssi_pkg::*;

    localparam int unsigned CW = COORD_WIDTH_DEF;
    localparam int unsigned FB = FRAC_BITS_DEF;
    localparam int unsigned LATENCY = 4 * CW + FB + 16;
    localparam int N_RANDOM = 625;

    typedef struct {
        logic signed [CW-1:0] sx, sy, sz, vx, vy, vz, tx, ty, tz;
        logic        [CW-2:0] mr, tr;
    } sphere_req_t;

    typedef struct {
        logic          hit;
        logic [CW-2:0] toh;
        logic          zv;
    } contact_t;

    class contact_scoreboard;
        contact_t pending[$];
        int       n_errors;
        int       n_hits;
        int       n_zero;
        int       n_checked;

        function contact_t predict_contact(sphere_req_t r);
            logic signed [255:0] d[3];
            logic signed [255:0] v[3];
            logic signed [255:0] a, h, c, rr;
            logic        [255:0] hm, cm, h2, ac, disc, res, rem, bitv, tmp, num, q;
            contact_t            e;
            d[0] = $signed(r.sx) - $signed(r.tx);
            d[1] = $signed(r.sy) - $signed(r.ty);
            d[2] = $signed(r.sz) - $signed(r.tz);
            v[0] = $signed(r.vx);
            v[1] = $signed(r.vy);
            v[2] = $signed(r.vz);
            a = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
            h = d[0] * v[0] + d[1] * v[1] + d[2] * v[2];
            rr = $signed({225'd0, r.mr}) + $signed({225'd0, r.tr});
            c = d[0] * d[0] + d[1] * d[1] + d[2] * d[2] - rr * rr;
            e = '{hit: 1'b0, toh: '0, zv: 1'b0};
            if (a == 0) begin
                e.zv = 1'b1;
                return e;
            end
            hm = (h < 0) ? -h : h;
            cm = (c < 0) ? -c : c;
            h2 = hm * hm;
            ac = a * cm;
            if (c < 0) begin
                disc = h2 + ac;
            end else begin
                if (h2 < ac) return e;
                disc = h2 - ac;
            end
            // floor square root
            res = '0;
            rem = disc;
            bitv = 256'd1 << 254;
            while (bitv != 0) begin
                tmp = res + bitv;
                res = res >> 1;
                if (rem >= tmp) begin
                    rem = rem - tmp;
                    res = res + bitv;
                end
                bitv = bitv >> 2;
            end
            if (h <= 0 && c >= 0) num = hm - res;
            else if (h <= 0) num = hm + res;
            else if (c <= 0) num = res - hm;
            else return e;
            q = (num << FB) / a;
            e.hit = 1'b1;
            e.toh = (q > {1'b0, {(CW-1){1'b1}}}) ? {(CW-1){1'b1}} : q[CW-2:0];
            return e;
        endfunction

        function void note_request(sphere_req_t r);
            pending.push_back(predict_contact(r));
        endfunction

        function void check_result(logic hit, logic [CW-2:0] toh, logic zv);
            contact_t e;
            if (pending.size() == 0) begin
                $error("unexpected result hit=%0b time=%0h zero_velocity=%0b", hit, toh, zv);
                n_errors++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (e.hit) n_hits++;
            if (e.zv) n_zero++;
            if (hit !== e.hit) begin
                $error("hit: expected %0b actual %0b", e.hit, hit);
                n_errors++;
            end
            if (toh !== e.toh) begin
                $error("time_of_hit: expected %0h actual %0h", e.toh, toh);
                n_errors++;
            end
            if (zv !== e.zv) begin
                $error("zero_velocity: expected %0b actual %0b", e.zv, zv);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    sphere_req_t req;
    logic o_hit, o_zero_velocity;
    logic [CW-2:0] o_time_of_hit;

    contact_scoreboard sb = new();
    bit sending_done = 1'b0;
    bit no_idle = 1'b0;
    int n_sent = 0;

    always #5 i_clk = ~i_clk;

    swept_sphere_sphere_intersect dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_start_x      (req.sx),
        .i_start_y      (req.sy),
        .i_start_z      (req.sz),
        .i_dir_x        (req.vx),
        .i_dir_y        (req.vy),
        .i_dir_z        (req.vz),
        .i_mover_radius (req.mr),
        .i_target_x     (req.tx),
        .i_target_y     (req.ty),
        .i_target_z     (req.tz),
        .i_target_radius(req.tr),
        .empty          (empty),
        .pop            (pop),
        .o_hit          (o_hit),
        .o_time_of_hit  (o_time_of_hit),
        .o_zero_velocity(o_zero_velocity)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic sphere_req_t make_req(
        logic signed [CW-1:0] sx, sy, sz, vx, vy, vz,
        logic [CW-2:0] mr,
        logic signed [CW-1:0] tx, ty, tz,
        logic [CW-2:0] tr
    );
        sphere_req_t r;
        r.sx = sx; r.sy = sy; r.sz = sz;
        r.vx = vx; r.vy = vy; r.vz = vz;
        r.mr = mr;
        r.tx = tx; r.ty = ty; r.tz = tz;
        r.tr = tr;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] small_val(int unsigned bits);
        return $signed(CW'($urandom_range(0, (1 << bits) - 1))) -
               $signed(CW'(1 << (bits - 1)));
    endfunction

    function automatic sphere_req_t random_req();
        sphere_req_t r;
        int          mode;
        int unsigned sh;
        mode = $urandom_range(0, 9);
        r = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     (CW-1)'($urandom), $urandom, $urandom, $urandom,
                     (CW-1)'($urandom));
        if (mode == 0) begin
            r.vx = '0; r.vy = '0; r.vz = '0;
        end else if (mode >= 3) begin
            // nearby spheres aimed roughly at each other, or away from each other in mode 9
            r.tx = small_val(24); r.ty = small_val(24); r.tz = small_val(24);
            r.sx = small_val(24); r.sy = small_val(24); r.sz = small_val(24);
            sh = $urandom_range(0, 12);
            r.vx = ((r.tx - r.sx) >>> sh) + small_val(12);
            r.vy = ((r.ty - r.sy) >>> sh) + small_val(12);
            r.vz = ((r.tz - r.sz) >>> sh) + small_val(12);
            if (mode == 9) begin
                r.vx = -r.vx; r.vy = -r.vy; r.vz = -r.vz;
            end
            r.mr = (CW-1)'($urandom_range(0, 1 << 22));
            r.tr = (CW-1)'($urandom_range(0, 1 << 22));
        end else if (mode == 2) begin
            r.vx = small_val(2); r.vy = small_val(2); r.vz = small_val(2);
        end
        return r;
    endfunction

    task automatic send_request(sphere_req_t r);
        int g;
        g = idle_len();
        if (g > 0) begin
            push = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req = r;
        push = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(r);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic run_stimulus();
        localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
        localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
        localparam logic [CW-2:0] MAXR = {(CW-1){1'b1}};
        localparam logic signed [CW-1:0] ONE = 1 << FB;
        // zero velocity
        send_request(make_req(0, 0, 0, 0, 0, 0, ONE, 10*ONE, 0, 0, ONE));
        send_request(make_req(MAXC, MINC, MAXC, 0, 0, 0, MAXR, MINC, MAXC, MINC, MAXR));
        // straight approach along x
        send_request(make_req(0, 0, 0, ONE, 0, 0, ONE, 10*ONE, 0, 0, ONE));
        // moving away: both roots negative
        send_request(make_req(0, 0, 0, -ONE, 0, 0, ONE, 10*ONE, 0, 0, ONE));
        // clean miss, negative discriminant
        send_request(make_req(0, 0, 0, ONE, 0, 0, ONE, 10*ONE, 10*ONE, 0, ONE));
        // overlapping at the start
        send_request(make_req(0, 0, 0, ONE, ONE, 0, 5*ONE, ONE, 0, 0, 5*ONE));
        send_request(make_req(0, 0, 0, -ONE, 0, 0, 5*ONE, 0, 0, 0, 0));
        // just touching at the start
        send_request(make_req(0, 0, 0, -ONE, 0, 0, ONE, 2*ONE, 0, 0, ONE));
        send_request(make_req(0, 0, 0, ONE, 0, 0, ONE, 2*ONE, 0, 0, ONE));
        // grazing contact
        send_request(make_req(0, 0, 0, ONE, 0, 0, ONE, 10*ONE, 2*ONE, 0, ONE));
        // huge time, saturates
        send_request(make_req(MINC, 0, 0, 1, 0, 0, 0, MAXC, 0, 0, 0));
        send_request(make_req(0, 0, MINC, 0, 0, 1, 1, 0, 0, MAXC, 1));
        // extreme coordinates and velocities
        send_request(make_req(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXR,
                              MINC, MINC, MINC, MAXR));
        send_request(make_req(MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, MAXC, MAXC, MAXC, 0));
        send_request(make_req(MAXC, MINC, MAXC, MAXC, MINC, MAXC, MAXR,
                              MINC, MAXC, MINC, 0));
        send_request(make_req(MINC, MAXC, 0, MINC, MINC, MAXC, 0, MAXC, MINC, 0, MAXR));
        send_request(make_req(-1, -1, -1, -1, -1, -1, MAXR, 0, 0, 0, MAXR));
        send_request(make_req(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(0, 0, 0, MINC, 0, 0, MAXR, 0, 0, 0, MAXR));
        // diagonal approach with fractional time
        send_request(make_req(0, 0, 0, 3*ONE, 7*ONE, -5*ONE, ONE/3,
                              30*ONE, 70*ONE, -50*ONE, ONE/7));
        for (int i = 0; i < N_RANDOM; i++) begin
            no_idle = ((i / 80) % 3) == 1;
            send_request(random_req());
        end
        push = 1'b0;
        no_idle = 1'b0;
    endtask

    initial begin
        req = '{default: '0};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        run_stimulus();
        sending_done = 1'b1;
    end

    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            g = idle_len();
            if (g > 0) begin
                pop = 1'b0;
                repeat (g - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            pop = 1'b1;
            @(posedge i_clk);
            if (!empty) sb.check_result(o_hit, o_time_of_hit, o_zero_velocity);
        end
    end

    initial begin
        wait (sending_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 40) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked: %0d hits, %0d zero velocity",
                 n_sent, sb.n_checked, sb.n_hits, sb.n_zero);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", sb.pending.size());
        $display("Verification failed");
        $finish;
    end

endmodule

[swept_sphere_sphere_intersect.f]
+incdir+hdl
hdl/ssi_pkg.sv
hdl/ssi_front.sv
hdl/ssi_fifo.sv
hdl/ssi_wmul.sv
hdl/ssi_back.sv
hdl/swept_sphere_sphere_intersect.sv
verif/tb.sv
